@@ hw/rtl/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  // Action codes carried by an input word
  typedef enum logic [1:0] {
    ACT_PUT_CHAR  = 2'd0,
    ACT_NEW_LINE  = 2'd1,
    ACT_CLEAR     = 2'd2,
    ACT_READ_CELL = 2'd3
  } action_e;

  // White-on-black space
  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  // Attribute after reset: white on black
  localparam logic [7:0]  ATTR_RESET = 8'h0F;

  // Cell RAM strobes
  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

endpackage

@@ hw/rtl/tcw_cell_ram.sv @@
// Cell buffer RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic               clk_i,
  input  tcw_pkg::ram_ctl_t  ctl_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [15:0]        wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [15:0]        rdata_o
);
  import tcw_pkg::*;

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tcw_seq.sv @@
// Sequencer: cursor tracking and the copy / fill sweeps over the cell RAM.
`timescale 1ns / 1ps

module tcw_seq #(
  parameter int ROWS = 25,
  parameter int COLS = 80,
  parameter int RW   = 5,
  parameter int CW   = 7,
  parameter int AW   = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  tcw_pkg::action_e   action_i,
  input  logic [7:0]         char_code_i,
  input  logic [10:0]        cell_index_i,
  input  logic [7:0]         attr_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [15:0]        cell_data_o,
  output logic [RW-1:0]      row_o,
  output logic [CW-1:0]      col_o,
  output logic               scrolled_o,
  output tcw_pkg::ram_ctl_t  ram_ctl_o,
  output logic [AW-1:0]      waddr_o,
  output logic [15:0]        wdata_o,
  output logic [AW-1:0]      raddr_o,
  input  logic [15:0]        rdata_i
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_COPY = AW'(CELLS - COLS - 1);
  localparam logic [AW-1:0] LAST_ROW0 = AW'(CELLS - COLS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLS);
  localparam logic [RW-1:0] ROW_MAX   = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_MAX   = CW'(COLS - 1);

  typedef enum logic [4:0] {
    ST_BOOT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_COPY = 5'b00100,
    ST_FILL = 5'b01000,
    ST_READ = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] wa_q, wa_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] lin_q, lin_d;
  logic          done_q, done_d;
  logic [15:0]   data_q, data_d;
  logic          scr_q, scr_d;

  always_comb begin
    logic go_scroll;
    go_scroll = 1'b0;
    state_d   = state_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    wa_d      = wa_q;
    row_d     = row_q;
    col_d     = col_q;
    lin_d     = lin_q;
    done_d    = 1'b0;
    data_d    = data_q;
    scr_d     = scr_q;
    ram_ctl_o = '0;
    waddr_o   = wa_q;
    wdata_o   = rdata_i;
    raddr_o   = AW'(cnt_q + COLS_A);

    unique case (state_q)
      ST_BOOT, ST_FILL: begin
        ram_ctl_o.we = 1'b1;
        if (pend_q) begin
          // drain the last copied cell first
          pend_d = 1'b0;
        end else begin
          waddr_o = cnt_q;
          wdata_o = BLANK_CELL;
          if (cnt_q == LAST_CELL) begin
            state_d = ST_IDLE;
            done_d  = (state_q == ST_FILL);
            data_d  = '0;
          end else begin
            cnt_d = AW'(cnt_q + 1'b1);
          end
        end
      end
      ST_COPY: begin
        // read one row ahead, write back the word read last cycle
        ram_ctl_o.re = 1'b1;
        ram_ctl_o.we = pend_q;
        pend_d       = 1'b1;
        wa_d         = cnt_q;
        if (cnt_q == LAST_COPY) begin
          state_d = ST_FILL;
          cnt_d   = LAST_ROW0;
        end else begin
          cnt_d = AW'(cnt_q + 1'b1);
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        data_d  = rdata_i;
      end
      ST_IDLE: begin
        if (start_i) begin
          scr_d  = 1'b0;
          data_d = '0;
          unique case (action_i)
            ACT_PUT_CHAR: begin
              ram_ctl_o.we = 1'b1;
              waddr_o      = lin_q;
              wdata_o      = {attr_i, char_code_i};
              if (lin_q == LAST_CELL) begin
                go_scroll = 1'b1;
              end else begin
                done_d = 1'b1;
                lin_d  = AW'(lin_q + 1'b1);
                if (col_q == COL_MAX) begin
                  col_d = '0;
                  row_d = RW'(row_q + 1'b1);
                end else begin
                  col_d = CW'(col_q + 1'b1);
                end
              end
            end
            ACT_NEW_LINE: begin
              if (row_q == ROW_MAX) begin
                go_scroll = 1'b1;
              end else begin
                done_d = 1'b1;
                row_d  = RW'(row_q + 1'b1);
                col_d  = '0;
                lin_d  = AW'(lin_q - AW'(col_q) + COLS_A);
              end
            end
            ACT_CLEAR: begin
              state_d = ST_FILL;
              cnt_d   = '0;
              pend_d  = 1'b0;
              row_d   = '0;
              col_d   = '0;
              lin_d   = '0;
            end
            ACT_READ_CELL: begin
              if (32'(cell_index_i) < 32'(CELLS)) begin
                ram_ctl_o.re = 1'b1;
                raddr_o      = AW'(cell_index_i);
                state_d      = ST_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
          if (go_scroll) begin
            state_d = ST_COPY;
            cnt_d   = '0;
            pend_d  = 1'b0;
            scr_d   = 1'b1;
            row_d   = ROW_MAX;
            col_d   = '0;
            lin_d   = LAST_ROW0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BOOT;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      wa_q    <= '0;
      row_q   <= '0;
      col_q   <= '0;
      lin_q   <= '0;
      done_q  <= 1'b0;
      data_q  <= '0;
      scr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      wa_q    <= wa_d;
      row_q   <= row_d;
      col_q   <= col_d;
      lin_q   <= lin_d;
      done_q  <= done_d;
      data_q  <= data_d;
      scr_q   <= scr_d;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign cell_data_o = data_q;
  assign row_o       = row_q;
  assign col_o       = col_q;
  assign scrolled_o  = scr_q;

endmodule

@@ hw/rtl/text_console_writer.sv @@
// Top level of the text console writer: attribute register, sequencer and cell RAM.
`timescale 1ns / 1ps

// Text console writer. Holds a ROWS x COLS buffer of 16-bit cells (attribute
// in the high byte, character in the low byte) and a cursor. A command word
// is taken at a clock edge with start high and busy low; exactly one result
// word follows, shown for a single cycle with done_o high. The receiver
// cannot stall, so it must take every result word in that cycle.
// Command behaviour:
//   put char / new line without scroll: result in the cycle after accept,
//     and busy stays low, so a command may be given every cycle;
//   read cell: result after a registered RAM read and the result register;
//     out-of-range index answers 0 in the cycle after accept;
//   scroll: copy sweep of ROWS*COLS-COLS cells, a drain of the last copied
//     cell, then fill of the bottom row of COLS cells;
//   clear: fill of all ROWS*COLS cells (one blank written per cycle).
// After reset the buffer is blanked by a clearing pass over all ROWS*COLS
// cells with busy high. The attribute register (attr_we_i / attr_wdata_i)
// can be written at any time and applies to the next put char.
// cursor_row_o and cursor_col_o carry the low 5 and 7 bits of the cursor.

module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_index_i,
  input  logic        attr_we_i,
  input  logic [7:0]  attr_wdata_i,
  output logic        done_o,
  output logic [15:0] cell_data_o,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic        scrolled_o
);
  import tcw_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int AW = $clog2(ROWS * COLS);

  logic [7:0]    attr_q;
  ram_ctl_t      ram_ctl;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [RW+4:0] row_ext;
  logic [CW+6:0] col_ext;

  // Attribute register, white on black after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (attr_we_i) begin
      attr_q <= attr_wdata_i;
    end
  end

  tcw_seq #(
    .ROWS (ROWS),
    .COLS (COLS),
    .RW   (RW),
    .CW   (CW),
    .AW   (AW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .action_i     (action_e'(action_i)),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .attr_i       (attr_q),
    .busy_o       (busy),
    .done_o       (done_o),
    .cell_data_o  (cell_data_o),
    .row_o        (row),
    .col_o        (col),
    .scrolled_o   (scrolled_o),
    .ram_ctl_o    (ram_ctl),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_o      (raddr),
    .rdata_i      (rdata)
  );

  tcw_cell_ram #(
    .DEPTH (ROWS * COLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Cursor ports show the low bits of the row and column
  assign row_ext      = {5'b0, row};
  assign col_ext      = {7'b0, col};
  assign cursor_row_o = row_ext[4:0];
  assign cursor_col_o = col_ext[6:0];

endmodule
